@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/mceb_pkg.sv @@
// Shared types, constants and helpers of the color expansion blitter.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mceb_pkg;

  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int STATE_W  = 13;
  localparam int ADDR_W   = 27;
  localparam int COLOR_W  = 24;
  localparam int MASK_W   = 8;
  localparam int BIT_W    = 3;
  localparam int STRIDE_W = 15;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;

  localparam int FIFO_DEPTH_DEF = 4;

  // Item kinds on the input channel
  localparam logic MODE_SETUP = 1'b0;
  localparam logic MODE_MASK  = 1'b1;

  localparam logic [BIT_W-1:0] BIT_FIRST = 3'd7;
  localparam logic [BIT_W-1:0] BIT_LAST  = 3'd0;

  // Register reset values
  localparam logic [COORD_W-1:0] CLIP_X_RST = 12'd0;
  localparam logic [COORD_W-1:0] CLIP_Y_RST = 12'd0;
  localparam logic [DIM_W-1:0]   CLIP_W_RST = 13'd1024;
  localparam logic [DIM_W-1:0]   CLIP_H_RST = 13'd768;
  localparam logic [DIM_W-1:0]   SURF_W_RST = 13'd1024;
  localparam logic [COLOR_W-1:0] FG_RST     = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] BG_RST     = 24'h000000;

  typedef enum logic [2:0] {
    REG_CLIP_X   = 3'd0,
    REG_CLIP_Y   = 3'd1,
    REG_CLIP_W   = 3'd2,
    REG_CLIP_H   = 3'd3,
    REG_SURF_W   = 3'd4,
    REG_FG_COLOR = 3'd5,
    REG_BG_COLOR = 3'd6
  } reg_idx_t;

  typedef enum logic {
    KIND_SETUP = 1'b0,
    KIND_MASK  = 1'b1
  } kind_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [MASK_W-1:0]  mask_byte;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               run_last;
    logic               rect_done;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] clip_x;
    logic [COORD_W-1:0] clip_y;
    logic [DIM_W-1:0]   clip_w;
    logic [DIM_W-1:0]   clip_h;
    logic [DIM_W-1:0]   surface_width;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } cfg_t;

  // One classified item between front and back
  typedef struct packed {
    kind_t              kind;
    logic               rect_ok;
    logic [STATE_W-1:0] cols;
    logic [STATE_W-1:0] rows;
    logic [ADDR_W-1:0]  base;
    logic [MASK_W-1:0]  mask;
  } q_entry_t;

  // Byte distance between two rows: surface_width * 3
  function automatic logic [STRIDE_W-1:0] row_stride(input logic [DIM_W-1:0] sw);
    row_stride = {2'b00, sw} + {1'b0, sw, 1'b0};
  endfunction

endpackage

`default_nettype wire

@@ sv/mceb_regs.sv @@
// APB-style configuration registers of the blitter.
// Depends on mceb_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module mceb_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [mceb_pkg::APB_AW-1:0] paddr,
  input  wire logic [mceb_pkg::APB_DW-1:0] pwdata,
  output logic      [mceb_pkg::APB_DW-1:0] prdata,
  output logic                           pready,
  output mceb_pkg::cfg_t                 cfg
);
  import mceb_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  // Write on the access phase; out-of-map indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.clip_x        <= CLIP_X_RST;
      cfg_r.clip_y        <= CLIP_Y_RST;
      cfg_r.clip_w        <= CLIP_W_RST;
      cfg_r.clip_h        <= CLIP_H_RST;
      cfg_r.surface_width <= SURF_W_RST;
      cfg_r.fg_color      <= FG_RST;
      cfg_r.bg_color      <= BG_RST;
    end else if (wr_en) begin
      case (idx)
        REG_CLIP_X:   cfg_r.clip_x        <= pwdata[COORD_W-1:0];
        REG_CLIP_Y:   cfg_r.clip_y        <= pwdata[COORD_W-1:0];
        REG_CLIP_W:   cfg_r.clip_w        <= pwdata[DIM_W-1:0];
        REG_CLIP_H:   cfg_r.clip_h        <= pwdata[DIM_W-1:0];
        REG_SURF_W:   cfg_r.surface_width <= pwdata[DIM_W-1:0];
        REG_FG_COLOR: cfg_r.fg_color      <= pwdata[COLOR_W-1:0];
        REG_BG_COLOR: cfg_r.bg_color      <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_CLIP_X:   prdata = {20'd0, cfg_r.clip_x};
      REG_CLIP_Y:   prdata = {20'd0, cfg_r.clip_y};
      REG_CLIP_W:   prdata = {19'd0, cfg_r.clip_w};
      REG_CLIP_H:   prdata = {19'd0, cfg_r.clip_h};
      REG_SURF_W:   prdata = {19'd0, cfg_r.surface_width};
      REG_FG_COLOR: prdata = {8'd0, cfg_r.fg_color};
      REG_BG_COLOR: prdata = {8'd0, cfg_r.bg_color};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/mceb_front.sv @@
// Front end: accepts items, clips setup rectangles and computes the start
// address, then pushes classified entries to the queue. Uses mceb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mceb_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mceb_pkg::in_item_t in_data,
  input  wire mceb_pkg::cfg_t     cfg,
  output logic                    q_push,
  output mceb_pkg::q_entry_t      q_data,
  input  wire logic               q_full
);
  import mceb_pkg::*;

  // Stage A: classified item
  logic               a_valid_r, a_valid_nxt;
  kind_t              a_kind_r;
  logic               a_ok_r;
  logic [STATE_W-1:0] a_cols_r, a_rows_r, a_ocol_r, a_orow_r;
  logic [MASK_W-1:0]  a_mask_r;

  logic                     a_load;
  logic signed [DIM_W+1:0]  room_w, room_h, want_w, want_h, len_w, len_h;
  logic                     rect_ok;
  logic [STRIDE_W-1:0]      stride;
  logic [ADDR_W:0]          prod;
  logic [STRIDE_W-1:0]      ocol3;

  assign in_stall = a_valid_r && q_full;
  assign a_load   = in_valid && !in_stall;
  assign q_push   = a_valid_r && !q_full;

  // Clip the requested size against the room left in the clip region
  always_comb begin
    room_w  = $signed({2'b00, cfg.clip_w}) - $signed({3'b000, in_data.start_x});
    room_h  = $signed({2'b00, cfg.clip_h}) - $signed({3'b000, in_data.start_y});
    want_w  = $signed({3'b000, in_data.rect_width});
    want_h  = $signed({3'b000, in_data.rect_height});
    len_w   = (room_w < want_w) ? room_w : want_w;
    len_h   = (room_h < want_h) ? room_h : want_h;
    rect_ok = (len_w > 15'sd0) && (len_h > 15'sd0);
  end

  assign a_valid_nxt = a_load || (a_valid_r && !q_push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // Capture the classified item; hold while the queue is full
  always_ff @(posedge clk) begin
    if (a_load) begin
      a_kind_r <= (in_data.mode == MODE_MASK) ? KIND_MASK : KIND_SETUP;
      a_ok_r   <= rect_ok;
      a_cols_r <= len_w[STATE_W-1:0];
      a_rows_r <= len_h[STATE_W-1:0];
      a_ocol_r <= {1'b0, in_data.start_x} + {1'b0, cfg.clip_x};
      a_orow_r <= {1'b0, in_data.start_y} + {1'b0, cfg.clip_y};
      a_mask_r <= in_data.mask_byte;
    end
  end

  // Stage B: start address = origin_row * stride + origin_col * 3
  assign stride = row_stride(cfg.surface_width);
  assign prod   = {15'd0, a_orow_r} * {13'd0, stride};
  assign ocol3  = {1'b0, a_ocol_r, 1'b0} + {2'b00, a_ocol_r};

  always_comb begin
    q_data.kind    = a_kind_r;
    q_data.rect_ok = a_ok_r;
    q_data.cols    = a_cols_r;
    q_data.rows    = a_rows_r;
    q_data.base    = prod[ADDR_W-1:0] + {12'd0, ocol3};
    q_data.mask    = a_mask_r;
  end

endmodule

`default_nettype wire

@@ sv/mceb_fifo.sv @@
// Short queue of classified entries between front and back ends.
// Uses mceb_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module mceb_fifo #(
  parameter int DEPTH = mceb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mceb_pkg::q_entry_t push_data,
  output logic                    full,
  input  wire logic               pop,
  output mceb_pkg::q_entry_t      head,
  output logic                    empty
);
  import mceb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/mceb_back.sv @@
// Back end: holds the rectangle walk and expands mask bytes into one pixel
// write per cycle while not stalled, through an output register. Uses mceb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mceb_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mceb_pkg::q_entry_t q_head,
  input  wire logic               q_empty,
  output logic                    q_pop,
  input  wire mceb_pkg::cfg_t     cfg,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mceb_pkg::out_item_t     out_data
);
  import mceb_pkg::*;

  // Control
  logic               active_r, active_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  // Walk state and byte in progress
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [MASK_W-1:0]  byte_r, byte_nxt;
  logic [STATE_W-1:0] cols_r, cols_nxt, rows_r, rows_nxt;
  logic [STATE_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [ADDR_W-1:0]  row_addr_r, row_addr_nxt, pix_addr_r, pix_addr_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               can_emit, head_setup, head_mask, emit;
  logic [MASK_W-1:0]  cur_byte;
  logic [BIT_W-1:0]   cur_bit;
  logic [STATE_W-1:0] col_inc, row_inc;
  logic               col_last, done, run_last;
  logic [ADDR_W-1:0]  next_row_addr;

  assign can_emit   = !out_valid_r || !out_stall;
  assign head_setup = !q_empty && (q_head.kind == KIND_SETUP);
  assign head_mask  = !q_empty && (q_head.kind == KIND_MASK);
  assign emit       = busy_r ? can_emit : (head_mask && active_r && can_emit);
  assign q_pop      = !busy_r && (head_setup || (head_mask && (!active_r || can_emit)));

  assign cur_byte = busy_r ? byte_r : q_head.mask;
  assign cur_bit  = busy_r ? bit_r : BIT_FIRST;

  // Position of the pixel after this one
  assign col_inc       = col_r + 1'b1;
  assign row_inc       = row_r + 1'b1;
  assign col_last      = (col_inc >= cols_r);
  assign done          = col_last && (row_inc >= rows_r);
  assign run_last      = (cur_bit == BIT_LAST) || done;
  assign next_row_addr = row_addr_r + {12'd0, row_stride(cfg.surface_width)};

  always_comb begin
    active_nxt    = active_r;
    busy_nxt      = busy_r;
    bit_nxt       = bit_r;
    byte_nxt      = byte_r;
    cols_nxt      = cols_r;
    rows_nxt      = rows_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    row_addr_nxt  = row_addr_r;
    pix_addr_nxt  = pix_addr_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = emit || (out_valid_r && out_stall);

    // Setup: restart the walk, or drop the rectangle if clipped away
    if (q_pop && head_setup) begin
      active_nxt   = q_head.rect_ok;
      cols_nxt     = q_head.cols;
      rows_nxt     = q_head.rows;
      col_nxt      = '0;
      row_nxt      = '0;
      row_addr_nxt = q_head.base;
      pix_addr_nxt = q_head.base;
    end

    // Pixel: write the output register and step in raster order
    if (emit) begin
      out_data_nxt.pixel_address = pix_addr_r;
      out_data_nxt.pixel_color   = cur_byte[cur_bit] ? cfg.fg_color : cfg.bg_color;
      out_data_nxt.run_last      = run_last;
      out_data_nxt.rect_done     = done;
      byte_nxt = cur_byte;
      bit_nxt  = cur_bit - 1'b1;
      busy_nxt = !run_last;
      if (col_last) begin
        col_nxt      = '0;
        row_nxt      = row_inc;
        row_addr_nxt = next_row_addr;
        pix_addr_nxt = next_row_addr;
      end else begin
        col_nxt      = col_inc;
        pix_addr_nxt = pix_addr_r + 27'd3;
      end
      if (done) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    byte_r     <= byte_nxt;
    cols_r     <= cols_nxt;
    rows_r     <= rows_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    row_addr_r <= row_addr_nxt;
    pix_addr_r <= pix_addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/mono_color_expand_blit.sv @@
// Top level of the monochrome color expansion blitter.
// Depends on mceb_pkg, mceb_regs, mceb_front, mceb_fifo and mceb_back.
//
// A setup item clips a rectangle against the clip region and fixes its
// surface origin; each following mask byte turns into up to eight pixel
// writes (address, color) in raster order, one per clock unless the output
// stalls, set by the single pixel stepper in the back end; a setup item or
// a byte that arrives with no rectangle pending yields no pixel write. The
// front end clips and computes the start address in one register stage and
// takes a new item every cycle until the entry queue (FIFO_DEPTH entries)
// fills, so the input keeps flowing while results wait on a stalled output.
// An item reaches its first pixel through the front-end register, the entry
// queue and the back-end output register. The user must write configuration
// through the APB port while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module mono_color_expand_blit #(
  parameter int FIFO_DEPTH = mceb_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire mceb_pkg::in_item_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output mceb_pkg::out_item_t              out_data,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mceb_pkg::APB_AW-1:0] paddr,
  input  wire logic [mceb_pkg::APB_DW-1:0] pwdata,
  output logic      [mceb_pkg::APB_DW-1:0] prdata,
  output logic                             pready
);
  import mceb_pkg::*;

  cfg_t     cfg;
  q_entry_t q_in, q_head;
  logic     q_push, q_pop, q_full, q_empty;

  mceb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mceb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  mceb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mceb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ sv/mceb_port_checker.sv @@
// Port-level checks of the blitter, bound to the top level below.
// Depends on mceb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mceb_port_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire mceb_pkg::out_item_t  out_data
);
  import mceb_pkg::*;

  // Stalled result holds
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

  // End of rectangle also ends the byte's run
  `CHK_ASSERT(a_done_ends_run, clk, rst_n, out_valid |-> (!out_data.rect_done || out_data.run_last), "rect_done without run_last")

  // Reset empties both channels
  `CHK_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall, "channels busy after reset")

  // A run of pixels inside one byte never skips ahead without a transfer
  `CHK_ASSERT(a_run_hold, clk, rst_n, out_valid && out_stall && !out_data.run_last |=> !out_data.run_last, "run end appeared while stalled")

endmodule

bind mono_color_expand_blit mceb_port_checker u_port_checker (.*);

`default_nettype wire
